[hdl/asa_pkg.sv]
package asa_pkg;

   // channel count and derived widths
   localparam int CHANNELS = 8;
   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int IDX_W = (CH_W > 3) ? CH_W : 3;

   // reset value of the step counter reload register
   localparam logic [7:0] FILTER_STEPS_RESET = 8'd8;

   // configuration register indexes
   localparam logic [1:0] CSR_FILTER_ENABLE = 2'd0;
   localparam logic [1:0] CSR_FILTER_STEPS = 2'd1;

   // input actions
   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_READ = 1'b1;

   typedef struct packed {
      logic        action;
      logic [15:0] sample;
      logic [2:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  select_channel;
      logic        store_valid;
      logic [2:0]  store_channel;
      logic [15:0] store_value;
      logic [15:0] read_data;
   } rsp_type;

   typedef struct packed {
      logic       filter_enable;
      logic [7:0] filter_steps;
   } cfg_type;

   // scan step outcome handed from the filter to the table logic
   typedef struct packed {
      logic [CH_W-1:0] select;
      logic            valid;
      logic [CH_W-1:0] channel;
      logic [15:0]     value;
   } store_type;

endpackage

[hdl/asa_ram.sv]
module asa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/asa_filter.sv]
module asa_filter (
   input  logic               clock,
   input  logic               reset,
   input  asa_pkg::cfg_type   cfg,
   input  logic               step_en,
   input  logic [15:0]        sample,
   output asa_pkg::store_type store
);
   import asa_pkg::*;

   logic [CH_W-1:0] cur_ff, cur_in;
   logic [7:0]      step_ff, step_in;
   logic [15:0]     run_ff, run_in;
   logic [CH_W-1:0] cur_next, cur_prev;
   logic [15:0]     run_new;

   // round-robin neighbors of the current channel
   assign cur_next = (cur_ff == CH_W'(CHANNELS - 1)) ? '0 : cur_ff + CH_W'(1);
   assign cur_prev = (cur_ff == '0) ? CH_W'(CHANNELS - 1) : cur_ff - CH_W'(1);

   // halving average seeded by the sample, each half rounded down
   assign run_new = (step_ff == cfg.filter_steps) ? sample
                  : 16'({1'b0, sample[15:1]} + {1'b0, run_ff[15:1]});

   // next state and store decision for one conversion transaction
   always_comb begin
      cur_in = cur_ff;
      step_in = step_ff;
      run_in = run_ff;
      store.valid = 1'b0;
      store.channel = '0;
      store.value = '0;
      if (step_en) begin
         if (!cfg.filter_enable) begin
            store.valid = 1'b1;
            store.channel = cur_prev;
            store.value = sample;
            cur_in = cur_next;
         end else begin
            run_in = run_new;
            if (step_ff != 8'd0) begin
               step_in = step_ff - 8'd1;
            end else begin
               step_in = cfg.filter_steps;
               store.valid = 1'b1;
               store.channel = cur_ff;
               store.value = run_new;
               cur_in = cur_next;
            end
         end
      end
      store.select = cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
         step_ff <= FILTER_STEPS_RESET;
         run_ff <= '0;
      end else begin
         cur_ff <= cur_in;
         step_ff <= step_in;
         run_ff <= run_in;
      end
   end

endmodule

[hdl/adc_scan_averager.sv]
// channel   ports                            width  role
// req       req_valid req_ready req_data     20     conversion result or table read
// rsp       rsp_valid rsp_ready rsp_data     39     next channel, store, read data
// csr       csr_valid csr_ready csr_index    2+8    filter_enable (0), filter_steps (1)
//           csr_data
//
// one transaction per cycle unless stalled; its result appears in the next cycle
// the channel table sits in a registered-read ram, so read data is registered
// req_ready drops only while a result waits and rsp_ready is low
// sync reset clears channel, running value and table valid bits, presets counter
// csr writes are taken every cycle
module adc_scan_averager (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  asa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output asa_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [7:0]       csr_data
);
   import asa_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   logic            req_fire;
   logic            step_en;
   logic            rd_en;
   store_type       store;
   logic [IDX_W-1:0] ridx_ext;
   logic [CH_W-1:0] rd_addr;
   logic            rd_in_range;
   logic [CHANNELS-1:0] valid_ff, valid_in;
   logic [15:0]     ram_rd_data;

   logic            out_valid_ff, out_valid_in;
   logic            out_read_ff;
   logic            out_hit_ff;
   logic [2:0]      out_sel_ff;
   logic            out_st_valid_ff;
   logic [2:0]      out_st_ch_ff;
   logic [15:0]     out_st_val_ff;

   // handshakes
   assign csr_ready = 1'b1;
   assign req_ready = !out_valid_ff || rsp_ready;
   assign req_fire = req_valid && req_ready;
   assign step_en = req_fire && (req_data.action == ACT_SAMPLE);
   assign rd_en = req_fire && (req_data.action == ACT_READ);

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FILTER_ENABLE: cfg_in.filter_enable = csr_data[0];
            CSR_FILTER_STEPS:  cfg_in.filter_steps = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_enable <= 1'b1;
         cfg_ff.filter_steps <= FILTER_STEPS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   asa_filter u_filter (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .step_en (step_en),
      .sample  (req_data.sample),
      .store   (store)
   );

   // table read address
   assign ridx_ext = IDX_W'(req_data.read_index);
   assign rd_addr = ridx_ext[CH_W-1:0];
   assign rd_in_range = 32'(req_data.read_index) < CHANNELS;

   asa_ram #(
      .WIDTH (16),
      .DEPTH (CHANNELS)
   ) u_table (
      .clock   (clock),
      .wr_en   (store.valid),
      .wr_addr (store.channel),
      .wr_data (store.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // per-entry written flags, unwritten entries read as zero
   always_comb begin
      valid_in = valid_ff;
      if (store.valid) begin
         valid_in[store.channel] = 1'b1;
      end
   end

   // output slot
   always_comb begin
      out_valid_in = out_valid_ff;
      if (req_fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         out_read_ff <= (req_data.action == ACT_READ);
         out_hit_ff <= rd_in_range && valid_ff[rd_addr];
         out_sel_ff <= 3'(store.select);
         out_st_valid_ff <= store.valid;
         out_st_ch_ff <= 3'(store.channel);
         out_st_val_ff <= store.value;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data.select_channel = out_sel_ff;
   assign rsp_data.store_valid = out_st_valid_ff;
   assign rsp_data.store_channel = out_st_ch_ff;
   assign rsp_data.store_value = out_st_val_ff;
   assign rsp_data.read_data = (out_read_ff && out_hit_ff) ? ram_rd_data : 16'd0;

   // table is never written and read in the same cycle
   assert property (@(posedge clock) disable iff (reset) !(store.valid && rd_en))
      else $error("table write and read in one cycle");

   // every accepted transaction shows up as a result in the next cycle
   assert property (@(posedge clock) disable iff (reset) req_fire |=> rsp_valid)
      else $error("accepted transaction lost");

   // a read transaction never reports a store
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_read_ff |-> !rsp_data.store_valid)
      else $error("store reported on a read");

   // input stalls only behind a waiting result
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without cause");

endmodule
